// ===== hdl/ate_pkg.sv =====
// Shared types and constants for the airfoil thickness evaluator.
// Used by every module of the block; it depends on nothing.
`timescale 1ns / 1ps

package ate_pkg;

    localparam int POS_W     = 24;
    localparam int THICK_W   = 7;
    localparam int CT_W      = POS_W + THICK_W;
    localparam int CFG_IDX_W = 2;
    localparam int COEF_BITS = 30;
    localparam int COEF_W    = 30;

    localparam logic [CFG_IDX_W-1:0] CFG_CHORD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THICK = 2'd1;

    localparam logic [THICK_W-1:0] THICK_RESET = 7'd12;

    // Polynomial coefficients, rounded to nearest with COEF_BITS fraction bits.
    localparam logic [COEF_W-1:0] COEF_SQRT =
        COEF_W'(((64'd2969 << COEF_BITS) + 64'd5000) / 64'd10000);
    localparam logic [COEF_W-1:0] COEF_Z1 =
        COEF_W'(((64'd1260 << COEF_BITS) + 64'd5000) / 64'd10000);
    localparam logic [COEF_W-1:0] COEF_Z2 =
        COEF_W'(((64'd3516 << COEF_BITS) + 64'd5000) / 64'd10000);
    localparam logic [COEF_W-1:0] COEF_Z3 =
        COEF_W'(((64'd2843 << COEF_BITS) + 64'd5000) / 64'd10000);
    localparam logic [COEF_W-1:0] COEF_Z4 =
        COEF_W'(((64'd1015 << COEF_BITS) + 64'd5000) / 64'd10000);

    // floor(n / 5) = (n * RECIP_5) >> RECIP_SHIFT for every n below 2^32.
    localparam int          RECIP_W     = 32;
    localparam logic [31:0] RECIP_5     = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 34;

    typedef struct packed {
        logic valid;
        logic clamped;
    } t_flags;

endpackage

// ===== hdl/ate_div_cell.sv =====
// One restoring division cell: produces one quotient bit per item.
// Depends on ate_pkg for the flag struct and field widths.
`timescale 1ns / 1ps

module ate_div_cell #(
    parameter int QW = 21
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  ate_pkg::t_flags           i_flags,
    input  logic [ate_pkg::POS_W-1:0] i_rem,
    input  logic [QW-1:0]             i_quo,
    input  logic [ate_pkg::POS_W-1:0] i_divisor,
    output ate_pkg::t_flags           o_flags,
    output logic [ate_pkg::POS_W-1:0] o_rem,
    output logic [QW-1:0]             o_quo
);

    logic [ate_pkg::POS_W:0]   n_shift;
    logic [ate_pkg::POS_W:0]   n_diff;
    logic                      n_ge;
    ate_pkg::t_flags           r_flags;
    logic [ate_pkg::POS_W-1:0] r_rem;
    logic [QW-1:0]             r_quo;

    always_comb begin
        n_shift = {i_rem, 1'b0};
        n_diff  = n_shift - {1'b0, i_divisor};
        n_ge    = (n_shift >= {1'b0, i_divisor});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_en) begin
            r_flags <= i_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_ge ? n_diff[ate_pkg::POS_W-1:0] : n_shift[ate_pkg::POS_W-1:0];
            r_quo <= {i_quo[QW-2:0], n_ge};
        end
    end

    assign o_flags = r_flags;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;

endmodule

// ===== hdl/ate_sqrt_cell.sv =====
// One square-root cell: consumes two radicand bits and yields one root bit.
// Depends on ate_pkg for the flag struct.
`timescale 1ns / 1ps

module ate_sqrt_cell #(
    parameter int FRAC_BITS = 20
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  ate_pkg::t_flags          i_flags,
    input  logic [FRAC_BITS+2:0]     i_rem,
    input  logic [FRAC_BITS:0]       i_root,
    input  logic [2*FRAC_BITS+1:0]   i_rad,
    input  logic [FRAC_BITS:0]       i_z,
    output ate_pkg::t_flags          o_flags,
    output logic [FRAC_BITS+2:0]     o_rem,
    output logic [FRAC_BITS:0]       o_root,
    output logic [2*FRAC_BITS+1:0]   o_rad,
    output logic [FRAC_BITS:0]       o_z
);

    localparam int RTW = FRAC_BITS + 1;
    localparam int RW  = FRAC_BITS + 3;
    localparam int VW  = 2 * FRAC_BITS + 2;

    logic [RW+1:0]   n_cur;
    logic [RW+1:0]   n_trial;
    logic [RW+1:0]   n_diff;
    logic            n_ge;
    ate_pkg::t_flags r_flags;
    logic [RW-1:0]   r_rem;
    logic [RTW-1:0]  r_root;
    logic [VW-1:0]   r_rad;
    logic [RTW-1:0]  r_z;

    always_comb begin
        n_cur   = {i_rem, i_rad[VW-1 -: 2]};
        n_trial = {2'b00, i_root, 2'b01};
        n_diff  = n_cur - n_trial;
        n_ge    = (n_cur >= n_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_en) begin
            r_flags <= i_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_ge ? n_diff[RW-1:0] : n_cur[RW-1:0];
            r_root <= {i_root[RTW-2:0], n_ge};
            r_rad  <= {i_rad[VW-3:0], 2'b00};
            r_z    <= i_z;
        end
    end

    assign o_flags = r_flags;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_rad   = r_rad;
    assign o_z     = r_z;

endmodule

// ===== hdl/ate_poly.sv =====
// Polynomial, thickness scaling and saturation, eight register stages.
// Depends on ate_pkg for coefficients, reciprocal and the flag struct.
`timescale 1ns / 1ps

module ate_poly #(
    parameter int FRAC_BITS = 20
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  ate_pkg::t_flags           i_flags,
    input  logic [FRAC_BITS:0]        i_z,
    input  logic [FRAC_BITS:0]        i_root,
    input  logic [ate_pkg::CT_W-1:0]  i_ct,
    output ate_pkg::t_flags           o_flags,
    output logic [ate_pkg::POS_W-1:0] o_result
);

    localparam int ZW    = FRAC_BITS + 1;
    localparam int PRW   = 2 * ZW;
    localparam int CPW   = ate_pkg::COEF_W + ZW;
    localparam int PW    = FRAC_BITS + 34;
    localparam int PFW   = FRAC_BITS;
    localparam int PRODW = ate_pkg::CT_W + PFW;
    localparam int QHW   = PRODW - FRAC_BITS - 2;
    localparam int QW2   = QHW + ate_pkg::RECIP_W;
    localparam int QTW   = QW2 - ate_pkg::RECIP_SHIFT;

    function automatic logic signed [PW-1:0] coef_mul(
        input logic [ate_pkg::COEF_W-1:0] coef,
        input logic [ZW-1:0]              x
    );
        logic [CPW-1:0] prod;
        prod = CPW'(coef) * CPW'(x);
        return $signed(PW'(prod));
    endfunction

    ate_pkg::t_flags         r_flags [1:8];
    logic [ZW-1:0]           r_s1_s, r_s1_z, r_s1_z2;
    logic [ZW-1:0]           r_s2_z, r_s2_z2, r_s2_z3;
    logic [ZW-1:0]           r_s3_z2, r_s3_z3, r_s3_z4;
    logic [ZW-1:0]           r_s4_z4;
    logic signed [PW-1:0]    r_s2_a, r_s3_acc, r_s4_acc, r_s4_d, r_s5_acc;
    logic [PFW-1:0]          r_pf;
    logic [PRODW-1:0]        r_prod;
    logic [QW2-1:0]          r_q;
    logic [PRW-1:0]          n_zz, n_zz2, n_zz3;
    logic [QTW-1:0]          n_quot;

    always_comb begin
        n_zz   = PRW'(i_z) * PRW'(i_z);
        n_zz2  = PRW'(r_s1_z2) * PRW'(r_s1_z);
        n_zz3  = PRW'(r_s2_z3) * PRW'(r_s2_z);
        n_quot = r_q[QW2-1:ate_pkg::RECIP_SHIFT];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= 8; k++) begin
                r_flags[k] <= '0;
            end
        end else if (i_en) begin
            r_flags[1] <= i_flags;
            for (int k = 2; k <= 8; k++) begin
                r_flags[k] <= r_flags[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_s   <= i_root;
            r_s1_z   <= i_z;
            r_s1_z2  <= n_zz[FRAC_BITS +: ZW];

            r_s2_z   <= r_s1_z;
            r_s2_z2  <= r_s1_z2;
            r_s2_z3  <= n_zz2[FRAC_BITS +: ZW];
            r_s2_a   <= coef_mul(ate_pkg::COEF_SQRT, r_s1_s);

            r_s3_z2  <= r_s2_z2;
            r_s3_z3  <= r_s2_z3;
            r_s3_z4  <= n_zz3[FRAC_BITS +: ZW];
            r_s3_acc <= r_s2_a - coef_mul(ate_pkg::COEF_Z1, r_s2_z);

            r_s4_z4  <= r_s3_z4;
            r_s4_acc <= r_s3_acc - coef_mul(ate_pkg::COEF_Z2, r_s3_z2);
            r_s4_d   <= coef_mul(ate_pkg::COEF_Z3, r_s3_z3);

            r_s5_acc <= r_s4_acc + r_s4_d - coef_mul(ate_pkg::COEF_Z4, r_s4_z4);

            // A negative polynomial value is taken as zero.
            r_pf     <= (r_s5_acc > 0) ? r_s5_acc[ate_pkg::COEF_BITS +: PFW] : '0;

            r_prod   <= PRODW'(i_ct) * PRODW'(r_pf);

            // Divide by 20 * 2^FRAC_BITS: shift out 2^(FRAC_BITS+2), then divide by 5.
            r_q      <= QW2'(r_prod[PRODW-1:FRAC_BITS+2]) * QW2'(ate_pkg::RECIP_5);
        end
    end

    assign o_flags  = r_flags[8];
    assign o_result = (|n_quot[QTW-1:ate_pkg::POS_W]) ? '1 : n_quot[ate_pkg::POS_W-1:0];

endmodule

// ===== hdl/airfoil_thickness_evaluator.sv =====
// Top level of the airfoil half-thickness evaluator.
// Depends on ate_pkg, ate_div_cell, ate_sqrt_cell and ate_poly.
//
// Usage:
//   Input channel i_valid / o_stall carries i_position; output channel
//   o_valid / i_stall carries o_half_thickness and o_clamped. An item moves
//   on an edge where valid is high and stall is low.
//   Configuration: i_cfg_valid with i_cfg_index and i_cfg_data; o_cfg_ready is
//   always high. Index 0 sets the chord, index 1 the thickness digits; other
//   indexes are ignored. Write only while no item is in flight.
//   One item per cycle is accepted while o_stall is low. The pipeline holds
//   one input register, FRAC_BITS division cells, FRAC_BITS + 1 square-root
//   cells, eight polynomial stages and the output register; the division
//   and square-root cell chains make up most of its depth.
//   When the receiver stalls, the result in the output register holds and
//   one more result lands in a skid register; o_stall is that skid register's
//   valid bit, and the whole pipeline holds while it is set.
//   Reset clears all valid bits and sets the chord to 1.0 and thickness to 12.
`timescale 1ns / 1ps

module airfoil_thickness_evaluator #(
    parameter int FRAC_BITS = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [ate_pkg::POS_W-1:0]     i_position,
    output logic                          o_stall,
    output logic                          o_valid,
    output logic [ate_pkg::POS_W-1:0]     o_half_thickness,
    output logic                          o_clamped,
    input  logic                          i_stall,
    input  logic                          i_cfg_valid,
    input  logic [ate_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ate_pkg::POS_W-1:0]     i_cfg_data,
    output logic                          o_cfg_ready
);

    localparam int QW = FRAC_BITS + 1;
    localparam int RW = FRAC_BITS + 3;
    localparam int VW = 2 * FRAC_BITS + 2;
    localparam logic [ate_pkg::POS_W-1:0] CHORD_RESET = ate_pkg::POS_W'(64'd1 << FRAC_BITS);

    logic [ate_pkg::POS_W-1:0]   r_chord;
    logic [ate_pkg::THICK_W-1:0] r_thick;
    logic [ate_pkg::CT_W-1:0]    r_ct;

    logic                        n_en;
    logic                        n_over;
    logic [ate_pkg::POS_W-1:0]   n_pc;
    logic                        n_q0;
    logic                        n_take;

    ate_pkg::t_flags             r_in_flags;
    logic [ate_pkg::POS_W-1:0]   r_in_rem;
    logic [QW-1:0]               r_in_quo;

    ate_pkg::t_flags             w_dflags [0:FRAC_BITS];
    logic [ate_pkg::POS_W-1:0]   w_drem   [0:FRAC_BITS];
    logic [QW-1:0]               w_dquo   [0:FRAC_BITS];

    ate_pkg::t_flags             w_sflags [0:FRAC_BITS+1];
    logic [RW-1:0]               w_srem   [0:FRAC_BITS+1];
    logic [QW-1:0]               w_sroot  [0:FRAC_BITS+1];
    logic [VW-1:0]               w_srad   [0:FRAC_BITS+1];
    logic [QW-1:0]               w_sz     [0:FRAC_BITS+1];

    ate_pkg::t_flags             w_fin_flags;
    logic [ate_pkg::POS_W-1:0]   w_fin_res;

    logic                        r_out_valid;
    logic [ate_pkg::POS_W-1:0]   r_out_res;
    logic                        r_out_clamped;
    logic                        r_skid_valid;
    logic [ate_pkg::POS_W-1:0]   r_skid_res;
    logic                        r_skid_clamped;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chord <= CHORD_RESET;
            r_thick <= ate_pkg::THICK_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ate_pkg::CFG_CHORD: r_chord <= i_cfg_data;
                ate_pkg::CFG_THICK: r_thick <= i_cfg_data[ate_pkg::THICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_ct <= ate_pkg::CT_W'(r_chord) * ate_pkg::CT_W'(r_thick);
    end

    assign o_cfg_ready = 1'b1;

    // Input stage: clamp to the chord and resolve the integer quotient bit.
    always_comb begin
        n_en   = !r_skid_valid;
        n_over = (i_position > r_chord);
        n_pc   = n_over ? r_chord : i_position;
        n_q0   = (n_pc >= r_chord);
        n_take = r_out_valid && !i_stall;
    end

    assign o_stall = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_flags <= '0;
        end else if (n_en) begin
            r_in_flags.valid   <= i_valid;
            r_in_flags.clamped <= n_over;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_in_rem <= n_q0 ? (n_pc - r_chord) : n_pc;
            r_in_quo <= {{(QW-1){1'b0}}, n_q0};
        end
    end

    assign w_dflags[0] = r_in_flags;
    assign w_drem[0]   = r_in_rem;
    assign w_dquo[0]   = r_in_quo;

    for (genvar g = 0; g < FRAC_BITS; g++) begin : g_div
        ate_div_cell #(
            .QW (QW)
        ) u_div_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (n_en),
            .i_flags   (w_dflags[g]),
            .i_rem     (w_drem[g]),
            .i_quo     (w_dquo[g]),
            .i_divisor (r_chord),
            .o_flags   (w_dflags[g+1]),
            .o_rem     (w_drem[g+1]),
            .o_quo     (w_dquo[g+1])
        );
    end

    assign w_sflags[0] = w_dflags[FRAC_BITS];
    assign w_srem[0]   = '0;
    assign w_sroot[0]  = '0;
    assign w_srad[0]   = {1'b0, w_dquo[FRAC_BITS], {FRAC_BITS{1'b0}}};
    assign w_sz[0]     = w_dquo[FRAC_BITS];

    for (genvar g = 0; g <= FRAC_BITS; g++) begin : g_sqrt
        ate_sqrt_cell #(
            .FRAC_BITS (FRAC_BITS)
        ) u_sqrt_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (n_en),
            .i_flags (w_sflags[g]),
            .i_rem   (w_srem[g]),
            .i_root  (w_sroot[g]),
            .i_rad   (w_srad[g]),
            .i_z     (w_sz[g]),
            .o_flags (w_sflags[g+1]),
            .o_rem   (w_srem[g+1]),
            .o_root  (w_sroot[g+1]),
            .o_rad   (w_srad[g+1]),
            .o_z     (w_sz[g+1])
        );
    end

    ate_poly #(
        .FRAC_BITS (FRAC_BITS)
    ) u_poly (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (n_en),
        .i_flags  (w_sflags[FRAC_BITS+1]),
        .i_z      (w_sz[FRAC_BITS+1]),
        .i_root   (w_sroot[FRAC_BITS+1]),
        .i_ct     (r_ct),
        .o_flags  (w_fin_flags),
        .o_result (w_fin_res)
    );

    // Output register with one skid entry. The pipeline holds while the skid is full.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (n_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_fin_flags.valid) begin
            if (!r_out_valid || n_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (n_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (n_take) begin
                r_out_res     <= r_skid_res;
                r_out_clamped <= r_skid_clamped;
            end
        end else if (w_fin_flags.valid) begin
            if (!r_out_valid || n_take) begin
                r_out_res     <= w_fin_res;
                r_out_clamped <= w_fin_flags.clamped;
            end else begin
                r_skid_res     <= w_fin_res;
                r_skid_clamped <= w_fin_flags.clamped;
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_half_thickness = r_out_res;
    assign o_clamped        = r_out_clamped;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without an output item");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && i_stall))
        else $error("skid entry filled while the output was free");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_stall) |=> (!r_skid_valid && r_out_valid))
        else $error("skid entry did not move to the output register");

    a_pipe_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |=> $stable(w_fin_flags))
        else $error("pipeline advanced while the skid entry was full");
`endif

endmodule
